>>> sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, arctangent table and handshake structs of the odometry
// core and its arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF  = 24;
    localparam int POSITION_BITS_DEF = 48;

    localparam int IN_W    = 24;
    localparam int TIME_W  = 20;
    localparam int POS_W   = 48;
    localparam int ANG_W   = 32;
    localparam int VEL_W   = 32;
    localparam int CFG_W   = 32;
    localparam int SLIP_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_AXLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP = 1'b1;

    localparam logic [31:0] AXLE_RESET = 32'd13107200;
    localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
    localparam logic [31:0] INV_GAIN   = 32'h9B74EDA8;
    localparam logic [31:0] VEL_SCALE  = 32'd1000000;

    // Divider: dividend, divisor and quotient widths.
    localparam int DIV_N = 69;
    localparam int DSR_W = 52;
    localparam int QUO_W = 33;
    localparam logic [QUO_W-1:0] CAP_POS = 33'd2147483647;
    localparam logic [QUO_W-1:0] CAP_NEG = 33'd2147483648;

    // Rotator vector and angle widths.
    localparam int CX_W = 44;
    localparam int CZ_W = 34;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
        logic             ovf;
    } t_div_rsp;

    typedef struct packed {
        logic                   start;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cordic_req;

    typedef struct packed {
        logic                   done;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
    } t_cordic_rsp;

    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/ddo_if.sv
// ----------------------------------------------------------------------------
// Odometry channel interfaces
// Valid/ready channels for wheel travel words and pose words.
// ----------------------------------------------------------------------------
`default_nettype none
interface ddo_in_if;
    import ddo_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [IN_W-1:0]   left_delta;
    logic signed [IN_W-1:0]   right_delta;
    logic        [TIME_W-1:0] step_time_us;

    modport source (output valid, left_delta, right_delta, step_time_us, input ready);
    modport sink   (input valid, left_delta, right_delta, step_time_us, output ready);
endinterface

interface ddo_out_if;
    import ddo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic        [ANG_W-1:0] heading;
    logic signed [VEL_W-1:0] lin_vel;
    logic signed [VEL_W-1:0] ang_vel;

    modport source (output valid, pos_x, pos_y, heading, lin_vel, ang_vel, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, lin_vel, ang_vel, output ready);
endinterface
`default_nettype wire

>>> sv/ddo_div.sv
// ----------------------------------------------------------------------------
// Odometry divider
// Restoring radix-2 divider, one quotient bit per cycle. Keeps the low
// quotient bits and a sticky flag for any higher bit that was set.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ddo_pkg::t_div_req i_req,
    output ddo_pkg::t_div_rsp      o_rsp
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DIV_N-1:0] r_dvd;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;

    logic [DSR_W:0]   rem_sh;
    logic             ge;
    logic [DSR_W-1:0] n_rem;

    assign rem_sh = {r_rem, r_dvd[DIV_N-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign n_rem  = ge ? DSR_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DSR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DIV_N-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_ovf <= r_ovf | r_quo[QUO_W-1];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.ovf  = r_ovf;

endmodule
`default_nettype wire

>>> sv/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Odometry CORDIC rotator
// Rotates a vector by a binary angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ddo_pkg::t_cordic_req i_req,
    output ddo_pkg::t_cordic_rsp      o_rsp
);
    import ddo_pkg::*;

    localparam logic [4:0] LAST = 5'(STEPS - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [4:0]             r_i;
    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [CZ_W-1:0] r_z;

    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [CZ_W-1:0] at;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = signed'({2'b00, atan_bam(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_i == LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_req.x;
            r_y <= i_req.y;
            r_z <= i_req.z;
        end else if (r_busy) begin
            if (!r_z[CZ_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;

endmodule
`default_nettype wire

>>> sv/diff_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// Differential-drive odometry core
// Integrates wheel travel into an x/y/heading pose and reports velocities.
// ----------------------------------------------------------------------------
// Usage:
// A word on i_in carries left and right wheel travel and the step time. The
// core takes one word at a time; i_in.ready is high only while the sequencer
// is idle. Each word produces exactly one pose word on o_out.
// The time from the accepting edge to o_out.valid is set mainly by the
// one-bit-per-cycle divider, used three times per word (heading change,
// linear and angular velocity), and by the CORDIC rotator at one
// micro-rotation per cycle. A single 32x32 multiplier serves all products.
// The finished pose sits in an output register, so a new word is accepted
// while the previous result still waits; if the receiver stalls longer, the
// sequencer holds its last step until the output register is free.
// Reset clears the pose and heading, sets axle_track to 200 mm and slippage
// to zero, and drops o_out.valid. Configuration writes are taken at any
// cycle through i_cfg_we and should only occur while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module diff_drive_odometry_core #(
    parameter int CORDIC_STEPS  = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_BITS = ddo_pkg::POSITION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ddo_in_if.sink                               i_in,
    ddo_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ddo_pkg::CFG_W-1:0]       i_cfg_data
);
    import ddo_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_H, S_DIV_H, S_WAIT_H, S_ANG, S_CORD, S_WAIT_C,
        S_UN_LO, S_UN_HI, S_UN_ADD, S_UN_SAT, S_MUL_L, S_DIV_L, S_WAIT_L,
        S_MUL_A1, S_MUL_A2, S_DIV_A, S_WAIT_A, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0]              r_axle;
    logic signed [SLIP_W-1:0] r_slip;
    logic signed [PB-1:0]     r_pose_x;
    logic signed [PB-1:0]     r_pose_y;
    logic [ANG_W-1:0]         r_heading;

    logic signed [IN_W:0]     r_s;
    logic signed [IN_W:0]     r_d;
    logic [TIME_W-1:0]        r_t;
    logic [63:0]              r_prod;
    logic [63:0]              r_plo;
    logic [63:0]              r_tmp;
    logic [ANG_W-1:0]         r_dth;
    logic [ANG_W-1:0]         r_ang;
    logic                     r_fold;
    logic signed [CX_W-1:0]   r_cy;
    logic [CX_W-1:0]          r_cmag;
    logic                     r_cneg;
    logic                     r_axis;
    logic signed [28:0]       r_un;
    logic [VEL_W-1:0]         r_lin;
    logic [VEL_W-1:0]         r_angv;

    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_o_x;
    logic signed [POS_W-1:0]  r_o_y;
    logic [ANG_W-1:0]         r_o_head;
    logic [VEL_W-1:0]         r_o_lin;
    logic [VEL_W-1:0]         r_o_ang;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_cordic_req cor_req;
    t_cordic_rsp cor_rsp;

    logic [IN_W:0]          mag_s;
    logic [IN_W:0]          mag_d;
    logic [SLIP_W:0]        mag_slip;
    logic [31:0]            axle_eff;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic signed [IN_W:0]   in_s;
    logic signed [IN_W:0]   in_d;
    logic [ANG_W-1:0]       dth_new;
    logic [ANG_W-1:0]       half;
    logic [ANG_W-1:0]       ang_mid;
    logic                   fold_new;
    logic signed [CX_W-1:0] x_base;
    logic signed [CX_W-1:0] y_base;
    logic [95:0]            un_sum;
    logic [27:0]            un_mag;
    logic signed [PB:0]     pose_sum;
    logic signed [PB-1:0]   pose_cur;
    logic signed [PB-1:0]   pose_sat;
    logic [QUO_W-1:0]       vel_cap;
    logic [QUO_W-1:0]       vel_mag;
    logic                   vel_neg;
    logic [VEL_W-1:0]       vel_val;
    logic signed [63:0]     ext_x;
    logic signed [63:0]     ext_y;

    assign in_s = {i_in.left_delta[IN_W-1], i_in.left_delta}
                + {i_in.right_delta[IN_W-1], i_in.right_delta};
    assign in_d = {i_in.right_delta[IN_W-1], i_in.right_delta}
                - {i_in.left_delta[IN_W-1], i_in.left_delta};

    assign mag_s    = r_s[IN_W] ? (IN_W+1)'(-r_s) : r_s;
    assign mag_d    = r_d[IN_W] ? (IN_W+1)'(-r_d) : r_d;
    assign mag_slip = r_slip[SLIP_W-1] ? (SLIP_W+1)'(-r_slip) : {1'b0, r_slip};
    assign axle_eff = (r_axle == '0) ? 32'd1 : r_axle;

    // Single shared multiplier; operands follow the sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_H: begin
                mul_a = 32'(mag_d);
                mul_b = RAD_TO_BAM;
            end
            S_ANG: begin
                mul_a = 32'(mag_s);
                mul_b = 32'(mag_slip);
            end
            S_UN_LO: begin
                mul_a = r_cmag[31:0];
                mul_b = INV_GAIN;
            end
            S_UN_HI: begin
                mul_a = 32'(r_cmag[CX_W-1:32]);
                mul_b = INV_GAIN;
            end
            S_MUL_L, S_MUL_A1: begin
                mul_a = (r_state == S_MUL_L) ? 32'(mag_s) : 32'(mag_d);
                mul_b = VEL_SCALE;
            end
            S_MUL_A2: begin
                mul_a = axle_eff;
                mul_b = 32'(r_t);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_DIV_H: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N'(r_prod) << 8;
                div_req.divisor  = DSR_W'(axle_eff);
            end
            S_DIV_L: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N'(r_prod);
                div_req.divisor  = DSR_W'({r_t, 1'b0});
            end
            S_DIV_A: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N'(r_tmp) << 24;
                div_req.divisor  = DSR_W'(r_prod);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Heading change, mid-step angle and the half-turn fold.
    assign dth_new  = r_d[IN_W] ? ANG_W'(32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
    assign half     = {r_dth[ANG_W-1], r_dth[ANG_W-1:1]};
    assign ang_mid  = r_heading + half;
    assign fold_new = ang_mid[ANG_W-2] ^ ang_mid[ANG_W-1];

    assign x_base = CX_W'(r_s) <<< 15;
    assign y_base = signed'({1'b0, r_prod[CX_W-2:0]});

    always_comb begin
        cor_req.start = (r_state == S_CORD);
        cor_req.x     = r_fold ? -x_base : x_base;
        cor_req.y     = (r_fold ^ r_slip[SLIP_W-1]) ? -y_base : y_base;
        cor_req.z     = CZ_W'(signed'(r_ang));
    end

    // Removal of the rotator gain: two partial products, then >> 48.
    assign un_sum = {r_prod[63:0], 32'd0} + {32'd0, r_plo};
    assign un_mag = un_sum[75:48];

    assign pose_cur = r_axis ? r_pose_y : r_pose_x;
    assign pose_sum = {pose_cur[PB-1], pose_cur} + (PB+1)'(r_un);
    assign pose_sat = (pose_sum[PB] != pose_sum[PB-1])
                    ? (pose_sum[PB] ? POS_MIN : POS_MAX) : pose_sum[PB-1:0];

    // Velocity saturation; the sign is that of the sum or the difference.
    assign vel_neg = (r_state == S_WAIT_L) ? r_s[IN_W] : r_d[IN_W];
    assign vel_cap = vel_neg ? CAP_NEG : CAP_POS;
    assign vel_mag = (div_rsp.ovf || (div_rsp.quot > vel_cap)) ? vel_cap : div_rsp.quot;
    assign vel_val = vel_neg ? VEL_W'(33'd0 - vel_mag) : vel_mag[VEL_W-1:0];

    assign ext_x = 64'(r_pose_x);
    assign ext_y = 64'(r_pose_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axle      <= AXLE_RESET;
            r_slip      <= '0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AXLE: r_axle <= i_cfg_data;
                    CFG_SLIP: r_slip <= i_cfg_data[SLIP_W-1:0];
                    default:  r_axle <= r_axle;
                endcase
            end
            // In the final step the output register is reloaded instead.
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= mul_a * mul_b;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_s     <= in_s;
                        r_d     <= in_d;
                        r_t     <= (i_in.step_time_us == '0) ? TIME_W'(1) : i_in.step_time_us;
                        r_state <= S_MUL_H;
                    end
                end
                S_MUL_H:  r_state <= S_DIV_H;
                S_DIV_H:  r_state <= S_WAIT_H;
                S_WAIT_H: begin
                    if (div_rsp.done) begin
                        r_dth   <= dth_new;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_fold  <= fold_new;
                    r_ang   <= fold_new ? ang_mid + 32'h8000_0000 : ang_mid;
                    r_state <= S_CORD;
                end
                S_CORD:   r_state <= S_WAIT_C;
                S_WAIT_C: begin
                    if (cor_rsp.done) begin
                        r_cy    <= cor_rsp.y;
                        r_cmag  <= CX_W'(cor_rsp.x[CX_W-1] ? -cor_rsp.x : cor_rsp.x);
                        r_cneg  <= cor_rsp.x[CX_W-1];
                        r_axis  <= 1'b0;
                        r_state <= S_UN_LO;
                    end
                end
                S_UN_LO:  r_state <= S_UN_HI;
                S_UN_HI: begin
                    r_plo   <= r_prod;
                    r_state <= S_UN_ADD;
                end
                S_UN_ADD: begin
                    r_un    <= r_cneg ? -signed'({1'b0, un_mag}) : signed'({1'b0, un_mag});
                    r_state <= S_UN_SAT;
                end
                S_UN_SAT: begin
                    if (!r_axis) begin
                        r_pose_x <= pose_sat;
                        r_cmag   <= CX_W'(r_cy[CX_W-1] ? -r_cy : r_cy);
                        r_cneg   <= r_cy[CX_W-1];
                        r_axis   <= 1'b1;
                        r_state  <= S_UN_LO;
                    end else begin
                        r_pose_y <= pose_sat;
                        r_state  <= S_MUL_L;
                    end
                end
                S_MUL_L:  r_state <= S_DIV_L;
                S_DIV_L:  r_state <= S_WAIT_L;
                S_WAIT_L: begin
                    if (div_rsp.done) begin
                        r_lin   <= vel_val;
                        r_state <= S_MUL_A1;
                    end
                end
                S_MUL_A1: r_state <= S_MUL_A2;
                S_MUL_A2: begin
                    r_tmp   <= r_prod;
                    r_state <= S_DIV_A;
                end
                S_DIV_A:  r_state <= S_WAIT_A;
                S_WAIT_A: begin
                    if (div_rsp.done) begin
                        r_angv  <= vel_val;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_heading   <= r_heading + r_dth;
                        r_o_x       <= ext_x[POS_W-1:0];
                        r_o_y       <= ext_y[POS_W-1:0];
                        r_o_head    <= r_heading + r_dth;
                        r_o_lin     <= r_lin;
                        r_o_ang     <= r_angv;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_o_x;
    assign o_out.pos_y   = r_o_y;
    assign o_out.heading = r_o_head;
    assign o_out.lin_vel = r_o_lin;
    assign o_out.ang_vel = r_o_ang;

endmodule
`default_nettype wire

>>> sv/ddo_checker.sv
// ----------------------------------------------------------------------------
// Odometry port checker
// Watches the channel ports of the odometry core over time.
// ----------------------------------------------------------------------------
`default_nettype none
module ddo_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_heading
);

    // Once a word is taken the core is busy and not ready right after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("core ready again right after accepting a word");

    // A stalled result word stays valid and its heading holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_heading))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind diff_drive_odometry_core ddo_checker u_ddo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_heading (o_out.heading)
);
`default_nettype wire
